>>> src/ogtg_pkg.sv
// ----------------------------------------------------------------------------
// ogtg_pkg
// Shared widths, constants and types of the occupancy grid tile graph block.
// ----------------------------------------------------------------------------
package ogtg_pkg;

	localparam int CELL_W       = 8;
	localparam int COORD_W      = 10;
	localparam int TILE_IDX_W   = 6;
	localparam int VERTEX_W     = 12;
	localparam int CFG_IDX_W    = 1;

	localparam int TILE_SIZE_DEF     = 10;
	localparam int MAX_TILE_COLS_DEF = 64;

	localparam logic signed [CELL_W-1:0] CELL_UNKNOWN  = -8'sd1;
	localparam logic signed [CELL_W-1:0] CELL_OCCUPIED = 8'sd100;

	localparam logic [COORD_W-1:0]  COLS_RESET = 10'd434;
	localparam logic [COORD_W-1:0]  ROWS_RESET = 10'd399;
	localparam logic [VERTEX_W-1:0] VERTEX_MAX = 12'd4095;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAP_COLUMNS = 1'b0,
		REG_MAP_ROWS    = 1'b1
	} reg_idx_t;

	// Position of the current cell as seen by the tile logic.
	typedef struct packed {
		logic [COORD_W-1:0] tile_row;
		logic [COORD_W-1:0] tile_col;
		logic               emit;
		logic               pad;
		logic               last;
	} pos_t;

	// One entry of the per-column band memory.
	typedef struct packed {
		logic                blk;
		logic [VERTEX_W-1:0] vertex;
	} entry_t;

endpackage

>>> src/ogtg_if.sv
// ----------------------------------------------------------------------------
// ogtg interfaces
// Valid/ready channels for cells, tiles and register writes.
// ----------------------------------------------------------------------------
interface ogtg_cell_if;
	import ogtg_pkg::*;
	logic                     valid;
	logic                     ready;
	logic signed [CELL_W-1:0] cell_value;
	modport source (output valid, output cell_value, input ready);
	modport sink   (input valid, input cell_value, output ready);
endinterface

interface ogtg_tile_if;
	import ogtg_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [TILE_IDX_W-1:0] tile_row;
	logic [TILE_IDX_W-1:0] tile_col;
	logic                  blocked;
	logic [VERTEX_W-1:0]   vertex_number;
	logic [VERTEX_W-1:0]   up_neighbour;
	logic [VERTEX_W-1:0]   left_neighbour;
	logic                  last_tile;
	modport source (output valid, output tile_row, output tile_col, output blocked,
		output vertex_number, output up_neighbour, output left_neighbour,
		output last_tile, input ready);
	modport sink   (input valid, input tile_row, input tile_col, input blocked,
		input vertex_number, input up_neighbour, input left_neighbour,
		input last_tile, output ready);
endinterface

interface ogtg_cfg_if;
	import ogtg_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] reg_index;
	logic [COORD_W-1:0]   wr_data;
	modport source (output valid, output reg_index, output wr_data, input ready);
	modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

>>> src/ogtg_ram.sv
// ----------------------------------------------------------------------------
// ogtg_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ogtg_ram #(
	parameter int WIDTH = ogtg_pkg::VERTEX_W + 1,
	parameter int DEPTH = ogtg_pkg::MAX_TILE_COLS_DEF
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end
endmodule

>>> src/ogtg_scan.sv
// ----------------------------------------------------------------------------
// ogtg_scan
// Raw and tile position counters of the incoming cell stream.
// ----------------------------------------------------------------------------
module ogtg_scan #(
	parameter int TILE_SIZE = ogtg_pkg::TILE_SIZE_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         advance,
	input  logic [ogtg_pkg::COORD_W-1:0] cols,
	input  logic [ogtg_pkg::COORD_W-1:0] rows,
	output ogtg_pkg::pos_t               pos
);
	import ogtg_pkg::*;

	localparam int OFF_W = $clog2(TILE_SIZE);
	localparam int TC_W  = $clog2((1 << COORD_W) / TILE_SIZE + 1);
	localparam int TE_W  = COORD_W + 1;
	localparam logic [OFF_W-1:0] OFF_LAST = OFF_W'(TILE_SIZE - 1);
	localparam logic [TE_W-1:0]  TE_STEP  = TE_W'(TILE_SIZE);

	logic [COORD_W-1:0] col_q, row_q;
	logic [OFF_W-1:0]   col_off_q, row_off_q;
	logic [TC_W-1:0]    tcol_q, trow_q;
	logic [TE_W-1:0]    col_end_q, row_end_q;
	logic               end_col, end_row, col_wrap, row_wrap;

	always_comb begin
		end_col  = ({1'b0, col_q} + 1'b1) >= {1'b0, cols};
		end_row  = ({1'b0, row_q} + 1'b1) >= {1'b0, rows};
		col_wrap = col_off_q == OFF_LAST;
		row_wrap = row_off_q == OFF_LAST;
		pos.tile_row = COORD_W'(trow_q);
		pos.tile_col = COORD_W'(tcol_q);
		pos.emit     = (col_wrap || end_col) && (row_wrap || end_row);
		pos.pad      = (col_end_q > {1'b0, cols}) || (row_end_q > {1'b0, rows});
		pos.last     = end_col && end_row;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q     <= '0;
			row_q     <= '0;
			col_off_q <= '0;
			row_off_q <= '0;
			tcol_q    <= '0;
			trow_q    <= '0;
			col_end_q <= TE_STEP;
			row_end_q <= TE_STEP;
		end else if (advance) begin
			if (end_col) begin
				col_q     <= '0;
				col_off_q <= '0;
				tcol_q    <= '0;
				col_end_q <= TE_STEP;
				if (end_row) begin
					row_q     <= '0;
					row_off_q <= '0;
					trow_q    <= '0;
					row_end_q <= TE_STEP;
				end else begin
					row_q <= row_q + 1'b1;
					if (row_wrap) begin
						row_off_q <= '0;
						trow_q    <= trow_q + 1'b1;
						row_end_q <= row_end_q + TE_STEP;
					end else begin
						row_off_q <= row_off_q + 1'b1;
					end
				end
			end else begin
				col_q <= col_q + 1'b1;
				if (col_wrap) begin
					col_off_q <= '0;
					tcol_q    <= tcol_q + 1'b1;
					col_end_q <= col_end_q + TE_STEP;
				end else begin
					col_off_q <= col_off_q + 1'b1;
				end
			end
		end
	end
endmodule

>>> src/occupancy_grid_tile_graph.sv
// Path: the last cell of a tile passes the band memory read and the stage 1
// registers, then the output register, which presents the tile.
// Throughput: one cell per cycle, except that a cell completing a tile waits in
// stage 1 while a tile waits untaken; other cells still pass a waiting tile.
// Reset: counters and valid bits clear at once, size registers take defaults;
// the band memory itself is never swept, so no clearing pass is needed.
// ----------------------------------------------------------------------------
// occupancy_grid_tile_graph
// Groups a row-major stream of occupancy cells into square tiles, numbers
// the free tiles and reports each tile with its free up and left neighbours.
// ----------------------------------------------------------------------------
module occupancy_grid_tile_graph #(
	parameter int TILE_SIZE     = ogtg_pkg::TILE_SIZE_DEF,
	parameter int MAX_TILE_COLS = ogtg_pkg::MAX_TILE_COLS_DEF
) (
	input logic          clk,
	input logic          arst_n,
	ogtg_cell_if.sink    cells,
	ogtg_tile_if.source  tile,
	ogtg_cfg_if.sink     cfg
);
	import ogtg_pkg::*;

	localparam int AW = $clog2(MAX_TILE_COLS);

	// Configuration registers. A zero setting behaves as one.
	logic [COORD_W-1:0] cols_q, rows_q;
	logic [COORD_W-1:0] cols_eff, rows_eff;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= COLS_RESET;
			rows_q <= ROWS_RESET;
		end else if (cfg.valid && cfg.ready) begin
			case (reg_idx_t'(cfg.reg_index))
				REG_MAP_COLUMNS: cols_q <= cfg.wr_data;
				REG_MAP_ROWS:    rows_q <= cfg.wr_data;
				default:         ;
			endcase
		end
	end

	assign cols_eff = (cols_q == '0) ? COORD_W'(1) : cols_q;
	assign rows_eff = (rows_q == '0) ? COORD_W'(1) : rows_q;

	// Stage 0: position of the cell being offered and band memory read.
	pos_t           pos;
	logic           accept;
	logic           bad;
	logic           in_range;
	logic [AW-1:0]  addr;

	assign accept   = cells.valid && cells.ready;
	assign bad      = (cells.cell_value == CELL_UNKNOWN) ||
	                  (cells.cell_value == CELL_OCCUPIED);
	assign in_range = pos.tile_col < COORD_W'(MAX_TILE_COLS);
	assign addr     = pos.tile_col[AW-1:0];

	ogtg_scan #(
		.TILE_SIZE (TILE_SIZE)
	) u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (accept),
		.cols    (cols_eff),
		.rows    (rows_eff),
		.pos     (pos)
	);

	// Stage 1 registers.
	logic                  s1_valid_q;
	logic                  bad_s1, emit_s1, pad_s1, last_s1, inr_s1;
	logic [AW-1:0]         addr_s1;
	logic [TILE_IDX_W-1:0] trow_s1, tcol_s1;
	logic                  vld_s1, hit_s1;
	entry_t                fwd_s1;

	// The band memory holds, per tile column, the blocking flag of the tile
	// being built in the current band and the vertex number of the tile last
	// emitted in that column. Entries without a valid bit read as zero; the
	// valid bits all drop when the last cell of a map is taken, which starts
	// the next map from an empty band.
	logic                     wr_en;
	entry_t                   wr_entry;
	logic [$bits(entry_t)-1:0] rd_raw;
	logic [MAX_TILE_COLS-1:0] ent_valid_q;

	ogtg_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (MAX_TILE_COLS)
	) u_band_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (addr_s1),
		.wr_data (wr_entry),
		.rd_en   (accept),
		.rd_addr (addr),
		.rd_data (rd_raw)
	);

	// Running vertex state, touched in stage 1 in cell order.
	logic [VERTEX_W-1:0] next_vertex_q, left_vertex_q;

	// Output register.
	logic                  out_valid_q;
	logic [TILE_IDX_W-1:0] tile_row_q, tile_col_q;
	logic                  blocked_q, last_tile_q;
	logic [VERTEX_W-1:0]   vertex_q, up_q, left_q;

	entry_t              cur;
	logic                blk;
	logic                emit_act;
	logic                out_free;
	logic                s1_go;
	logic [VERTEX_W-1:0] num, up_v, left_v;

	// A cell needing a result waits in stage 1 until the output register is
	// free; every other cell moves on at once.
	assign out_free  = !out_valid_q || tile.ready;
	assign emit_act  = inr_s1 && emit_s1;
	assign s1_go     = s1_valid_q && (!emit_act || out_free);
	assign cells.ready = !s1_valid_q || s1_go;

	always_comb begin
		// The write of the previous cell to the same column lands on the edge
		// that loaded this one, so it comes from the forwarding copy.
		if (hit_s1) begin
			cur = fwd_s1;
		end else if (vld_s1) begin
			cur = entry_t'(rd_raw);
		end else begin
			cur = '0;
		end
		blk    = cur.blk || bad_s1 || pad_s1;
		num    = blk ? '0 : next_vertex_q;
		up_v   = blk ? '0 : cur.vertex;
		left_v = (blk || addr_s1 == '0) ? '0 : left_vertex_q;
		if (emit_s1) begin
			wr_entry.blk    = 1'b0;
			wr_entry.vertex = num;
		end else begin
			wr_entry.blk    = cur.blk || bad_s1;
			wr_entry.vertex = cur.vertex;
		end
		// The last cell of a map writes nothing: the band clears behind it.
		wr_en = s1_go && inr_s1 && !last_s1;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			bad_s1  <= bad;
			emit_s1 <= pos.emit;
			pad_s1  <= pos.pad;
			last_s1 <= pos.last;
			inr_s1  <= in_range;
			addr_s1 <= addr;
			trow_s1 <= pos.tile_row[TILE_IDX_W-1:0];
			tcol_s1 <= pos.tile_col[TILE_IDX_W-1:0];
			vld_s1  <= ent_valid_q[addr];
			hit_s1  <= wr_en && (addr_s1 == addr);
			fwd_s1  <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			ent_valid_q <= '0;
		end else begin
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (s1_go) begin
				s1_valid_q <= 1'b0;
			end
			// Taking the last cell of a map empties the band, which also
			// covers a write of the cell ahead of it on the same edge.
			if (accept && pos.last) begin
				ent_valid_q <= '0;
			end else if (wr_en) begin
				ent_valid_q[addr_s1] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_vertex_q <= VERTEX_W'(1);
			left_vertex_q <= '0;
		end else if (s1_go) begin
			if (last_s1) begin
				next_vertex_q <= VERTEX_W'(1);
				left_vertex_q <= '0;
			end else if (emit_act) begin
				left_vertex_q <= num;
				// Numbering saturates at the top of the vertex range.
				if (!blk && next_vertex_q < VERTEX_MAX) begin
					next_vertex_q <= next_vertex_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go && emit_act) begin
			out_valid_q <= 1'b1;
		end else if (tile.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && emit_act) begin
			tile_row_q  <= trow_s1;
			tile_col_q  <= tcol_s1;
			blocked_q   <= blk;
			vertex_q    <= num;
			up_q        <= up_v;
			left_q      <= left_v;
			last_tile_q <= last_s1;
		end
	end

	assign tile.valid          = out_valid_q;
	assign tile.tile_row       = tile_row_q;
	assign tile.tile_col       = tile_col_q;
	assign tile.blocked        = blocked_q;
	assign tile.vertex_number  = vertex_q;
	assign tile.up_neighbour   = up_q;
	assign tile.left_neighbour = left_q;
	assign tile.last_tile      = last_tile_q;
endmodule

>>> src/ogtg_checker.sv
// ----------------------------------------------------------------------------
// ogtg_checker
// Port-level checks of the tile stream, bound to the top level.
// ----------------------------------------------------------------------------
module ogtg_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            tile_valid,
	input logic                            tile_ready,
	input logic [ogtg_pkg::TILE_IDX_W-1:0] tile_col,
	input logic                            blocked,
	input logic [ogtg_pkg::VERTEX_W-1:0]   vertex_number,
	input logic [ogtg_pkg::VERTEX_W-1:0]   up_neighbour,
	input logic [ogtg_pkg::VERTEX_W-1:0]   left_neighbour
);
	import ogtg_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		tile_valid && !tile_ready |=> tile_valid && $stable(vertex_number) &&
		$stable(blocked))
		else $error("tile changed while stalled");

	a_blocked_zero: assert property (@(posedge clk) disable iff (!arst_n)
		tile_valid && blocked |-> vertex_number == '0 && up_neighbour == '0 &&
		left_neighbour == '0)
		else $error("blocked tile carries vertex numbers");

	a_free_numbered: assert property (@(posedge clk) disable iff (!arst_n)
		tile_valid && !blocked |-> vertex_number != '0)
		else $error("free tile without vertex number");

	a_first_col: assert property (@(posedge clk) disable iff (!arst_n)
		tile_valid && tile_col == '0 |-> left_neighbour == '0)
		else $error("left neighbour in first tile column");
endmodule

bind occupancy_grid_tile_graph ogtg_checker u_ogtg_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.tile_valid     (tile.valid),
	.tile_ready     (tile.ready),
	.tile_col       (tile.tile_col),
	.blocked        (tile.blocked),
	.vertex_number  (tile.vertex_number),
	.up_neighbour   (tile.up_neighbour),
	.left_neighbour (tile.left_neighbour)
);

>>> dv/tb_occupancy_grid_tile_graph.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_occupancy_grid_tile_graph
// Streams occupancy cells into the tile graph block and checks every tile it
// reports against a cycle-free model kept in the bench. Map shapes, cell
// values, and register changes in the middle of a map are directed first and
// then randomized. Both channels idle in random bursts. One phase holds off
// the tile side long enough to back up the cell input. The run ends with a
// small map streamed with both sides always willing.
// ----------------------------------------------------------------------------
module tb_occupancy_grid_tile_graph;
	import ogtg_pkg::*;

	localparam int TS           = TILE_SIZE_DEF;
	localparam int NCOLS        = MAX_TILE_COLS_DEF;
	// Quiet time for the last tiles to leave through stage 1 and the output
	// register before a register write or before the end of the run.
	localparam int SETTLE       = 8;
	localparam int HOLD_CYCLES  = 150;
	localparam int RANDOM_CELLS = 120;
	localparam int RANDOM_AREA  = 120;
	localparam int PRINT_CAP    = 30;
	localparam int CYCLE_LIMIT  = 400000;

	// Cell content mixes: free only, mostly free with a few blocking cells,
	// or any 8-bit pattern.
	typedef enum int {FILL_FREE, FILL_MIXED, FILL_NOISE} fill_t;

	typedef struct packed {
		logic [TILE_IDX_W-1:0] row;
		logic [TILE_IDX_W-1:0] col;
		logic                  blocked;
		logic [VERTEX_W-1:0]   vertex;
		logic [VERTEX_W-1:0]   up;
		logic [VERTEX_W-1:0]   left;
		logic                  last;
	} tile_rec_t;

	logic clk = 1'b0;
	logic arst_n;

	ogtg_cell_if cell_ch ();
	ogtg_tile_if tile_ch ();
	ogtg_cfg_if  cfg_ch ();

	occupancy_grid_tile_graph i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cells  (cell_ch),
		.tile   (tile_ch),
		.cfg    (cfg_ch)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// Tile model. It advances one cell per accepted transfer and pushes
	// the tile that the cell completes, if any, onto tiles_due.
	// ------------------------------------------------------------------
	logic [COORD_W-1:0]  cols_reg;
	logic [COORD_W-1:0]  rows_reg;
	logic                band_hit [NCOLS];
	logic [VERTEX_W-1:0] col_vertex [NCOLS];
	logic [VERTEX_W-1:0] prev_vertex;
	logic [VERTEX_W-1:0] vertex_next;
	int unsigned         cur_row;
	int unsigned         cur_col;
	bit                  map_done;

	tile_rec_t   tiles_due [$];
	tile_rec_t   tile_want;
	int unsigned cells_sent;
	int unsigned maps_done;
	int unsigned tiles_seen;
	int unsigned mismatches;
	int unsigned cycle_count;

	bit src_idle_en;
	bit sink_idle_en;
	int stall_left;
	int hold_requests;
	int hold_served;
	int hold_left;

	// A finished map leaves the position at the origin with no history, so
	// the next cell starts a fresh map.
	function automatic void clear_map();
		for (int i = 0; i < NCOLS; i++) begin
			band_hit[i]   = 1'b0;
			col_vertex[i] = '0;
		end
		prev_vertex = '0;
		vertex_next = 1;
		cur_row     = 0;
		cur_col     = 0;
	endfunction

	function automatic void track_cell(input logic signed [CELL_W-1:0] v);
		int unsigned cols;
		int unsigned rows;
		int unsigned tc;
		int unsigned tr;
		bit          end_col;
		bit          end_row;
		bit          pad;
		bit          blk;
		tile_rec_t   t;
		// A zero register behaves as a one.
		cols    = (cols_reg == 0) ? 1 : cols_reg;
		rows    = (rows_reg == 0) ? 1 : rows_reg;
		tc      = cur_col / TS;
		tr      = cur_row / TS;
		// A position at or past the last column or row, which a register
		// shrunk mid-map can leave behind, counts as that last column or row.
		end_col = (cur_col + 1) >= cols;
		end_row = (cur_row + 1) >= rows;
		map_done = 1'b0;
		cells_sent++;
		// Cells of tile columns beyond the band memory are dropped.
		if (tc < NCOLS) begin
			if (v == CELL_UNKNOWN || v == CELL_OCCUPIED)
				band_hit[tc] = 1'b1;
			if ((cur_col % TS == TS - 1 || end_col) && (cur_row % TS == TS - 1 || end_row)) begin
				// A tile that sticks out past the map edge holds padding.
				pad = (tc + 1) * TS > cols || (tr + 1) * TS > rows;
				blk = band_hit[tc] || pad;
				t = '0;
				t.row = TILE_IDX_W'(tr);
				t.col = TILE_IDX_W'(tc);
				t.blocked = blk;
				t.last = end_col && end_row;
				if (!blk) begin
					t.vertex = vertex_next;
					// The count saturates, so late free tiles share the top number.
					if (vertex_next < VERTEX_MAX)
						vertex_next++;
					t.up   = col_vertex[tc];
					t.left = (tc != 0) ? prev_vertex : '0;
				end
				col_vertex[tc] = t.vertex;
				prev_vertex    = t.vertex;
				band_hit[tc]   = 1'b0;
				tiles_due.push_back(t);
			end
		end
		if (end_col && end_row) begin
			clear_map();
			map_done = 1'b1;
			maps_done++;
		end else if (end_col) begin
			cur_col = 0;
			cur_row = (cur_row + 1) & 10'h3FF;
		end else begin
			cur_col = (cur_col + 1) & 10'h3FF;
		end
	endfunction

	// ------------------------------------------------------------------
	// Tile checker: each tile transfer is matched with the oldest
	// prediction, field by field.
	// ------------------------------------------------------------------
	function automatic void check_field(input string name, input logic [VERTEX_W-1:0] want,
			input logic [VERTEX_W-1:0] got);
		if (got !== want) begin
			mismatches++;
			if (mismatches <= PRINT_CAP)
				$display("%0t: tile %0d field %s: expected %0d, actual %0d",
					$time, tiles_seen, name, want, got);
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && tile_ch.valid && tile_ch.ready) begin
			tiles_seen++;
			if (tiles_due.size() == 0) begin
				mismatches++;
				if (mismatches <= PRINT_CAP)
					$display("%0t: tile (%0d,%0d): expected no tile, actual vertex %0d",
						$time, tile_ch.tile_row, tile_ch.tile_col, tile_ch.vertex_number);
			end else begin
				tile_want = tiles_due.pop_front();
				check_field("tile_row", VERTEX_W'(tile_want.row),
					VERTEX_W'(tile_ch.tile_row));
				check_field("tile_col", VERTEX_W'(tile_want.col),
					VERTEX_W'(tile_ch.tile_col));
				check_field("blocked", VERTEX_W'(tile_want.blocked),
					VERTEX_W'(tile_ch.blocked));
				check_field("vertex_number", tile_want.vertex, tile_ch.vertex_number);
				check_field("up_neighbour", tile_want.up, tile_ch.up_neighbour);
				check_field("left_neighbour", tile_want.left, tile_ch.left_neighbour);
				check_field("last_tile", VERTEX_W'(tile_want.last),
					VERTEX_W'(tile_ch.last_tile));
			end
		end
	end

	// ------------------------------------------------------------------
	// Tile side ready. A hold request keeps ready low while hold_left runs
	// down from HOLD_CYCLES; otherwise ready drops in random bursts while
	// sink_idle_en is set.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (hold_requests != hold_served) begin
			hold_served = hold_requests;
			hold_left   = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			tile_ch.ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			tile_ch.ready <= 1'b0;
		end else if (sink_idle_en && $urandom_range(0, 9) == 0) begin
			stall_left = $urandom_range(1, 18) - 1;
			tile_ch.ready <= 1'b0;
		end else begin
			tile_ch.ready <= 1'b1;
		end
	end

	// Watchdog for a block that hangs or drops tiles.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d tiles still due", $time, tiles_due.size());
			$display("FAILED: results differ");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Channel tasks
	// ------------------------------------------------------------------

	// Offers one cell and returns at the edge of its transfer. Valid stays
	// high afterwards so back-to-back cells follow with no gap; wait_idle
	// lowers it at the end of a phase.
	task automatic send_cell(input logic signed [CELL_W-1:0] v);
		int gap;
		if (src_idle_en && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 18);
			cell_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cell_ch.valid      <= 1'b1;
		cell_ch.cell_value <= v;
		do @(posedge clk); while (!cell_ch.ready);
		track_cell(v);
	endtask

	// Leaves valid high; the caller lowers it after its last write.
	task automatic write_reg(input reg_idx_t idx, input int unsigned value);
		cfg_ch.valid     <= 1'b1;
		cfg_ch.reg_index <= idx;
		cfg_ch.wr_data   <= COORD_W'(value);
		do @(posedge clk); while (!cfg_ch.ready);
		if (idx == REG_MAP_COLUMNS)
			cols_reg = COORD_W'(value);
		else
			rows_reg = COORD_W'(value);
	endtask

	task automatic configure_map(input int unsigned cols, input int unsigned rows);
		write_reg(REG_MAP_COLUMNS, cols);
		write_reg(REG_MAP_ROWS, rows);
		cfg_ch.valid <= 1'b0;
	endtask

	// Waits until every predicted tile has arrived and the pipeline has had
	// time to drain cells that produce no tile.
	task automatic wait_idle();
		cell_ch.valid <= 1'b0;
		while (tiles_due.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic logic signed [CELL_W-1:0] gen_cell(input fill_t fill);
		int unsigned pick;
		pick = $urandom_range(0, 999);
		case (fill)
			FILL_FREE:  return CELL_W'($urandom_range(0, 99));
			FILL_NOISE: return CELL_W'($urandom_range(0, 255));
			default: begin
				if (pick < 3)
					return CELL_UNKNOWN;
				if (pick < 6)
					return CELL_OCCUPIED;
				if (pick < 20)
					return CELL_W'($urandom_range(0, 255));
				return CELL_W'($urandom_range(0, 99));
			end
		endcase
	endfunction

	// Sends cells until the model sees the map close.
	task automatic send_map(input fill_t fill);
		do send_cell(gen_cell(fill)); while (!map_done);
	endtask

	function automatic int unsigned pick_dim();
		if ($urandom_range(0, 1) == 1)
			return 10 * $urandom_range(1, 3);
		return $urandom_range(0, 35);
	endfunction

	task automatic pick_size(output int unsigned cols, output int unsigned rows);
		do begin
			cols = pick_dim();
			rows = pick_dim();
		end while (cols * rows > RANDOM_AREA);
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// With the row count set to one, a single row at the reset width of 434
	// gives 44 tiles, the last of them reaching past the right edge.
	task automatic test_reset_defaults();
		write_reg(REG_MAP_ROWS, 1);
		cfg_ch.valid <= 1'b0;
		send_map(FILL_MIXED);
		wait_idle();
	endtask

	// One-tile maps of free cells. The first tile carries every value next
	// to the blocking ones, including the ends of the 8-bit range, and stays
	// free; the next two each hold one unknown or one occupied cell.
	task automatic test_cell_values();
		logic signed [CELL_W-1:0] near [6];
		int unsigned spot;
		near = '{8'sh80, -8'sd2, 8'sd0, 8'sd99, 8'sd101, 8'sd127};
		configure_map(TS, TS);
		for (int i = 0; i < TS * TS; i++)
			send_cell((i % 16 == 0 && i / 16 < 6) ? near[i / 16] : gen_cell(FILL_FREE));
		spot = $urandom_range(0, TS * TS - 1);
		for (int i = 0; i < TS * TS; i++)
			send_cell((i == spot) ? CELL_UNKNOWN : gen_cell(FILL_FREE));
		spot = $urandom_range(0, TS * TS - 1);
		for (int i = 0; i < TS * TS; i++)
			send_cell((i == spot) ? CELL_OCCUPIED : gen_cell(FILL_FREE));
		wait_idle();
	endtask

	// Zero in both registers gives a one-cell map, so every cell is a padded
	// last tile. The values walk the extremes and alternating bit patterns.
	task automatic test_zero_registers();
		logic signed [CELL_W-1:0] probe [12];
		probe = '{8'sh80, -8'sd2, CELL_UNKNOWN, 8'sd0, 8'sd1, 8'sd99, CELL_OCCUPIED,
			8'sd101, 8'sd127, 8'sh55, 8'shAA, 8'shF0};
		configure_map(0, 0);
		foreach (probe[k])
			send_cell(probe[k]);
		wait_idle();
	endtask

	// With one tile per cell, a long hold on the tile side fills the
	// pipeline and the cell input must stall until ready returns.
	task automatic test_backpressure();
		src_idle_en  = 1'b0;
		sink_idle_en = 1'b0;
		configure_map(1, 1);
		hold_requests++;
		repeat (40) send_cell(gen_cell(FILL_NOISE));
		wait_idle();
		src_idle_en  = 1'b1;
		sink_idle_en = 1'b1;
	endtask

	// Registers shrink under a position that already lies past the new last
	// column, and later past the new last row.
	task automatic test_mid_map_shrink();
		configure_map(25, 10);
		repeat (22) send_cell(gen_cell(FILL_MIXED));
		wait_idle();
		configure_map(12, 10);
		send_map(FILL_MIXED);
		wait_idle();
		configure_map(10, 15);
		repeat (10 * 11) send_cell(gen_cell(FILL_MIXED));
		wait_idle();
		configure_map(10, 5);
		send_map(FILL_MIXED);
		wait_idle();
	endtask

	// A 641-wide row reaches one tile column beyond the band memory; that
	// column, which holds the final cell, is dropped.
	task automatic test_wide_map();
		configure_map(641, 1);
		send_map(FILL_MIXED);
		wait_idle();
	endtask

	// Random small maps, now and then reshaped in the middle, until enough
	// cells have gone through.
	task automatic test_random_maps();
		int unsigned cells_start;
		int unsigned cols;
		int unsigned rows;
		int unsigned pick;
		fill_t       fill;
		cells_start = cells_sent;
		while (cells_sent - cells_start < RANDOM_CELLS) begin
			src_idle_en  = ($urandom_range(0, 3) != 0);
			sink_idle_en = ($urandom_range(0, 3) != 0);
			pick = $urandom_range(0, 9);
			fill = (pick == 0) ? FILL_FREE : (pick == 1) ? FILL_NOISE : FILL_MIXED;
			pick_size(cols, rows);
			configure_map(cols, rows);
			if ($urandom_range(0, 7) == 0) begin
				repeat ((cols * rows) / 2) send_cell(gen_cell(fill));
				wait_idle();
				pick_size(cols, rows);
				configure_map(cols, rows);
			end
			send_map(fill);
			wait_idle();
		end
	endtask

	// A one-band map two tiles wide, of mostly free cells, streamed with no idling at all.
	task automatic test_steady_stream();
		configure_map(2 * TS, TS);
		send_map(FILL_MIXED);
		wait_idle();
	endtask

	initial begin
		cell_ch.valid      = 1'b0;
		cell_ch.cell_value = '0;
		cfg_ch.valid       = 1'b0;
		cfg_ch.reg_index   = REG_MAP_COLUMNS;
		cfg_ch.wr_data     = '0;
		tile_ch.ready      = 1'b0;
		arst_n             = 1'b0;
		cols_reg           = COLS_RESET;
		rows_reg           = ROWS_RESET;
		src_idle_en        = 1'b1;
		sink_idle_en       = 1'b1;
		clear_map();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_cell_values();
		test_zero_registers();
		test_backpressure();
		test_mid_map_shrink();
		test_wide_map();
		test_random_maps();

		// The closing stretch runs with both sides always willing.
		src_idle_en  = 1'b0;
		sink_idle_en = 1'b0;
		test_steady_stream();

		$display("Covered %0d cells over %0d maps and %0d checked tiles, %0d mismatches.",
			cells_sent, maps_done, tiles_seen, mismatches);
		$display("Maps ranged from one cell to 641 columns, with mid-map reshapes and stalls.");
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

>>> occupancy_grid_tile_graph.f
src/ogtg_pkg.sv
src/ogtg_if.sv
src/ogtg_ram.sv
src/ogtg_scan.sv
src/occupancy_grid_tile_graph.sv
src/ogtg_checker.sv
dv/tb_occupancy_grid_tile_graph.sv
